>>> rtl/core/psbd_pkg.sv
// Shared types and constants for the prefix subtree bitmap decoder.
// Holds the request and result item structs and the control/status bundles.
// No dependencies.
`timescale 1ns / 1ps

package psbd_pkg;

  // Default node count of the heap-indexed subtree bitmap
  localparam int TREE_NODES_DEF = 31;

  localparam int WordW = 32;
  localparam int LenW  = 6;

  // One request item
  typedef struct packed {
    logic [WordW-1:0] subtree_identifier;
    logic [WordW-1:0] subtree_bitmap;
    logic [WordW-1:0] origin_asn;
  } req_item_t;

  // One result item
  typedef struct packed {
    logic [WordW-1:0] prefix_value;
    logic [LenW-1:0]  min_length;
    logic [LenW-1:0]  max_length;
    logic [WordW-1:0] result_asn;
    logic             last_flag;
  } res_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture request item
    logic setup;  // find level and base prefix, arm scan
    logic step;   // examine one node
  } psbd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;       // zero identifier or no node in range
    logic rest_empty;  // no node left above the current one
  } psbd_stat_t;

endpackage

>>> rtl/core/psbd_ctrl.sv
// Controller for the prefix subtree bitmap decoder: idle, setup and scan states.
// Depends on psbd_pkg for the command and status bundles.
`timescale 1ns / 1ps

module psbd_ctrl import psbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  psbd_stat_t stat,
  output psbd_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN
  } state_t;

  state_t state;

  // Commands follow the state; load on accept
  always_comb begin
    cmd.load  = start && !busy;
    cmd.setup = (state == ST_SETUP);
    cmd.step  = (state == ST_SCAN);
  end

  // State and registered busy
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SETUP;
            busy  <= 1'b1;
          end
        end
        ST_SETUP: begin
          if (stat.empty) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat.rest_empty) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/psbd_datapath.sv
// Datapath for the prefix subtree bitmap decoder: item registers, node scan,
// subtree height, subtree clearing and the result register. Uses psbd_pkg.
`timescale 1ns / 1ps

module psbd_datapath import psbd_pkg::*; #(
  parameter int TREE_NODES = TREE_NODES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  psbd_cmd_t  cmd,
  input  req_item_t  request,
  output psbd_stat_t stat,
  output logic       result_valid,
  output res_item_t  result
);

  // Nodes 1 to TREE_NODES are in range
  localparam logic [WordW-1:0] NodeMask =
    WordW'(((64'd1 << (TREE_NODES + 1)) - 64'd1)) & ~WordW'(1);

  // floor(log2 n) for a node index
  function automatic logic [2:0] node_depth(input logic [4:0] n);
    logic [2:0] d;
    d = 3'd0;
    for (int b = 1; b < 5; b++) begin
      if (n[b]) d = 3'(b);
    end
    return d;
  endfunction

  // Item registers and scan state
  logic [WordW-1:0] ident;
  logic [WordW-1:0] remaining_nodes;
  logic [WordW-1:0] asn;
  logic [WordW-1:0] pfx;
  logic [4:0]       level;
  logic [4:0]       scan_position;

  // Setup: leading marker and left-aligned base prefix
  logic [4:0]       level_next;
  logic [5:0]       base_sh;
  logic [WordW-1:0] pfx_next;

  always_comb begin
    level_next = 5'd0;
    for (int b = 0; b < WordW; b++) begin
      if (ident[b]) level_next = 5'(b);
    end
    base_sh  = 6'd32 - {1'b0, level_next};
    pfx_next = (ident & ~(WordW'(1) << level_next)) << base_sh;
  end

  // Complete subtree height per node, bottom up
  logic [2:0] hgt [0:31];

  always_comb begin
    for (int k = 0; k < 32; k++) hgt[k] = 3'd0;
    for (int k = 15; k >= 1; k--) begin
      if (remaining_nodes[2*k] && remaining_nodes[2*k+1]) begin
        if (hgt[2*k] < hgt[2*k+1]) hgt[k] = hgt[2*k] + 3'd1;
        else                       hgt[k] = hgt[2*k+1] + 3'd1;
      end
    end
  end

  // Current node: lengths, prefix and clearing mask
  logic             hit;
  logic [2:0]       depth;
  logic [2:0]       h;
  logic [3:0]       tail;
  logic [5:0]       len;
  logic [5:0]       tail_sh;
  logic [63:0]      tail_wide;
  logic [WordW-1:0] prefix;
  logic [WordW-1:0] clr;
  logic [WordW-1:0] map_next;
  logic [2:0]       dm;
  logic [2:0]       dr;

  always_comb begin
    hit       = remaining_nodes[scan_position];
    depth     = node_depth(scan_position);
    h         = hgt[scan_position];
    tail      = scan_position[3:0] & 4'((5'd1 << depth) - 5'd1);
    len       = {1'b0, level} + {3'b0, depth};
    tail_sh   = 6'd32 - len;
    tail_wide = {60'd0, tail} << tail_sh;
    if (len <= 6'd32) prefix = pfx | tail_wide[31:0];
    else              prefix = pfx | {28'd0, tail >> 2'(len - 6'd32)};

    // Node m is cleared when it sits at most h levels below the current node
    clr = '0;
    for (int m = 1; m < 32; m++) begin
      dm = node_depth(5'(m));
      dr = dm - depth;
      if (dm >= depth && dr <= h && (5'(m) >> dr) == scan_position) clr[m] = 1'b1;
    end
    map_next = hit ? (remaining_nodes & ~clr) : remaining_nodes;
  end

  always_comb begin
    stat.empty      = (ident == '0) || (remaining_nodes == '0);
    stat.rest_empty = (map_next & (32'hFFFF_FFFE << scan_position)) == '0;
  end

  // Item capture and scan progress
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_nodes <= '0;
      scan_position   <= '0;
    end else if (cmd.load) begin
      ident           <= request.subtree_identifier;
      remaining_nodes <= request.subtree_bitmap & NodeMask;
      asn             <= request.origin_asn;
    end else if (cmd.setup) begin
      level         <= level_next;
      pfx           <= pfx_next;
      scan_position <= stat.empty ? 5'd0 : 5'd1;
      if (ident == '0) remaining_nodes <= '0;
    end else if (cmd.step) begin
      remaining_nodes <= map_next;
      scan_position   <= stat.rest_empty ? 5'd0 : scan_position + 5'd1;
    end
  end

  // Result register, one strobe per emitted node
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.step && hit;
    end
    if (cmd.step && hit) begin
      result.prefix_value <= prefix;
      result.min_length   <= len;
      result.max_length   <= len + {3'b0, h};
      result.result_asn   <= asn;
      result.last_flag    <= stat.rest_empty;
    end
  end

endmodule

>>> rtl/core/prefix_subtree_bitmap_decoder_top.sv
// Top level of the prefix subtree bitmap decoder: controller plus datapath.
// Depends on psbd_pkg, psbd_ctrl and psbd_datapath.
//
//   channel   signals                      handshake
//   request   start, busy, request         taken when start & !busy
//   result    result_valid, result         one-cycle strobe, never stalled
//
// An item passes through a setup state, then a scan that examines the nodes
// in turn from node 1 up to the last node still set after clearing, using
// the single node examiner in the datapath. A zero identifier or an empty
// bitmap finishes in the setup state with no result. Synchronous reset
// returns to idle with no strobe. The receiver takes each result in the
// cycle it is shown; busy stays high until the scan is done.
`timescale 1ns / 1ps

module prefix_subtree_bitmap_decoder_top import psbd_pkg::*; #(
  parameter int TREE_NODES = TREE_NODES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  req_item_t request,
  output logic      result_valid,
  output res_item_t result
);

  psbd_cmd_t  cmd;
  psbd_stat_t stat;

  // Sequencer
  psbd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Scan datapath
  psbd_datapath #(
    .TREE_NODES (TREE_NODES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .request      (request),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

>>> rtl/core/psbd_checker.sv
// Port-level checks for the prefix subtree bitmap decoder, bound to the top.
// Depends on psbd_pkg and prefix_subtree_bitmap_decoder_top.
`timescale 1ns / 1ps

module psbd_checker import psbd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input res_item_t result,
  input logic      result_valid
);

  // An accepted item keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // Results only come out of a running scan
  a_res_in_scan: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe without a running scan");

  // The final result of an item coincides with the block going idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_flag |-> !busy)
    else $error("busy after final result");

  // A result that is not final leaves the scan running
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_flag |-> busy)
    else $error("scan ended without a final result");

endmodule

bind prefix_subtree_bitmap_decoder_top psbd_checker u_psbd_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result       (result),
  .result_valid (result_valid)
);

>>> sim/tb.sv
// Self-checking bench for the prefix subtree bitmap decoder top level.
// Drives subtree records in random bursts, predicts every prefix entry and
// checks each result strobe in order. Depends on psbd_pkg and the RTL top.
`timescale 1ns / 1ps

module tb;
  import psbd_pkg::*;

  localparam int NODE_COUNT = TREE_NODES_DEF;
  localparam int RANDOM_ITEMS = 410;
  localparam int DRAIN_CYCLES = 40;

  logic      clk;
  logic      rst;
  logic      start = 1'b0;
  logic      busy;
  req_item_t request = '0;
  logic      result_valid;
  res_item_t result;

  // Items waiting to be sent, and the entries they are predicted to produce
  req_item_t pending_records[$];
  res_item_t expected_entries[$];

  int records_planned = 0;
  int records_taken   = 0;
  int zero_idents     = 0;
  int entries_checked = 0;
  int most_entries    = 0;
  int fault_count     = 0;
  int burst_left      = 0;
  int gap_left        = 0;
  res_item_t wanted;

  prefix_subtree_bitmap_decoder_top #(
    .TREE_NODES(NODE_COUNT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .result_valid(result_valid),
    .result      (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expand one accepted record into its prefix entries
  task automatic expand_record(input req_item_t rec);
    logic [31:0] bitmap_now;
    logic [31:0] base_bits;
    logic [31:0] base_prefix;
    logic [31:0] tail;
    logic [63:0] wide;
    int          level;
    int          depth;
    int          hgt;
    int          len;
    int          idx;
    int          produced;
    bit          full;
    bit          have_prev;
    res_item_t   entry;
    res_item_t   prev;
    produced  = 0;
    have_prev = 1'b0;
    if (rec.subtree_identifier == '0) begin
      // no marker bit: nothing to emit
      zero_idents++;
      return;
    end
    level = 31;
    while (!rec.subtree_identifier[level]) level--;
    base_bits = rec.subtree_identifier;
    base_bits[level] = 1'b0;
    base_prefix = (level == 0) ? '0 : base_bits << (32 - level);
    bitmap_now = rec.subtree_bitmap;
    for (int n = 1; n <= NODE_COUNT && n <= 31; n++) begin
      if (bitmap_now[n]) begin
        depth = 0;
        while ((n >> (depth + 1)) != 0) depth++;
        // grow the height while every node of the bottom row has both children
        hgt  = 0;
        full = 1'b1;
        while (full && hgt < 5) begin
          for (int k = 0; k < (1 << hgt); k++) begin
            idx = (n << hgt) + k;
            if (idx > 15 || 2 * idx + 1 > NODE_COUNT ||
                !bitmap_now[2 * idx] || !bitmap_now[2 * idx + 1])
              full = 1'b0;
          end
          if (full) hgt++;
        end
        tail = n & ((1 << depth) - 1);
        len  = level + depth;
        // path bits follow the base; past bit 32 they are shifted out instead
        if (len <= 32) begin
          wide = {32'd0, tail} << (32 - len);
          entry.prefix_value = base_prefix | wide[31:0];
        end else begin
          entry.prefix_value = base_prefix | (tail >> (len - 32));
        end
        entry.min_length = 6'(len);
        entry.max_length = 6'(len + hgt);
        entry.result_asn = rec.origin_asn;
        entry.last_flag  = 1'b0;
        if (have_prev) expected_entries.push_back(prev);
        prev      = entry;
        have_prev = 1'b1;
        produced++;
        // clear the complete subtree just reported
        for (int r = 0; r <= hgt && r < 5; r++) begin
          for (int k = 0; k < (1 << r); k++) begin
            idx = (n << r) + k;
            if (idx < 32) bitmap_now[idx] = 1'b0;
          end
        end
      end
    end
    if (have_prev) begin
      prev.last_flag = 1'b1;
      expected_entries.push_back(prev);
    end
    if (produced > most_entries) most_entries = produced;
  endtask

  // Sender: bursts of back-to-back items separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expand_record(request);
        records_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_records.size() != 0) begin
          request <= pending_records.pop_front();
          start   <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result checker: each strobe against the oldest predicted entry
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      if (expected_entries.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: unexpected entry prefix=%08h min=%0d max=%0d asn=%08h last=%0b",
                   $time, result.prefix_value, result.min_length, result.max_length,
                   result.result_asn, result.last_flag);
      end else begin
        wanted = expected_entries.pop_front();
        entries_checked++;
        if (result.prefix_value !== wanted.prefix_value ||
            result.min_length   !== wanted.min_length   ||
            result.max_length   !== wanted.max_length   ||
            result.result_asn   !== wanted.result_asn   ||
            result.last_flag    !== wanted.last_flag) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("%0t: entry mismatch", $time);
            $display("  want prefix=%08h min=%0d max=%0d asn=%08h last=%0b",
                     wanted.prefix_value, wanted.min_length, wanted.max_length,
                     wanted.result_asn, wanted.last_flag);
            $display("  got  prefix=%08h min=%0d max=%0d asn=%08h last=%0b",
                     result.prefix_value, result.min_length, result.max_length,
                     result.result_asn, result.last_flag);
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [31:0] ident;
    logic [31:0] bitmap;
    logic [31:0] asn;
    int          lvl;
    int          root;
    int          hgt;
    int          idx;
    int          roll;
    rst = 1'b1;

    // directed: identifier extremes, full and empty trees, long prefixes
    pending_records.push_back('{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    pending_records.push_back('{32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0000});
    pending_records.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF});
    pending_records.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678});
    pending_records.push_back('{32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h0000_0001});
    pending_records.push_back('{32'hFFFF_FFFF, 32'hFFFF_0000, 32'h8000_0000});
    pending_records.push_back('{32'h8000_0000, 32'h5555_5554, 32'h7FFF_FFFF});
    pending_records.push_back('{32'h0001_C0A8, 32'h0000_0000, 32'h0000_FDE8});
    pending_records.push_back('{32'h0001_C0A8, 32'h0000_0001, 32'h0000_FDE8});
    pending_records.push_back('{32'h0000_0100, 32'h0000_0002, 32'hFFFF_FFFF});
    pending_records.push_back('{32'h0000_0100, 32'h0000_000E, 32'h0000_0000});
    pending_records.push_back('{32'h0000_0002, 32'hFFFF_FFFC, 32'hA5A5_A5A5});
    pending_records.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'h5A5A_5A5A});
    pending_records.push_back('{32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0000});
    pending_records.push_back('{32'h0000_0003, 32'h0000_FFFE, 32'hFFFF_FFFF});
    pending_records.push_back('{32'h0000_0000, 32'h0000_0002, 32'h0000_0000});
    pending_records.push_back('{32'h0000_0005, 32'hFFFE_0006, 32'h0000_0064});
    pending_records.push_back('{32'h0000_0001, 32'h5555_5556, 32'hFFFF_FFFF});
    pending_records.push_back('{32'h4000_0000, 32'hFFFF_00FE, 32'h0000_0001});
    pending_records.push_back('{32'hFFFF_FFFF, 32'h0000_7FFE, 32'hFFFF_FFFF});

    // random records, half with bitmaps made of whole subtrees
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        ident = '0;
      end else if (roll < 16) begin
        ident = $urandom;
      end else begin
        lvl   = ($urandom_range(0, 3) == 0) ? $urandom_range(27, 31)
                                            : $urandom_range(0, 31);
        ident = ($urandom & ((32'd1 << lvl) - 32'd1)) | (32'd1 << lvl);
      end

      roll = $urandom_range(0, 9);
      if (roll < 3) begin
        bitmap = $urandom;
      end else if (roll < 8) begin
        bitmap = '0;
        repeat ($urandom_range(1, 4)) begin
          root = $urandom_range(1, 31);
          hgt  = $urandom_range(0, 4);
          for (int r = 0; r <= hgt; r++) begin
            for (int k = 0; k < (1 << r); k++) begin
              idx = (root << r) + k;
              if (idx < 32) bitmap[idx] = 1'b1;
            end
          end
        end
        if ($urandom_range(0, 1) == 1) bitmap[$urandom_range(0, 31)] ^= 1'b1;
        if ($urandom_range(0, 2) == 0) bitmap |= $urandom & $urandom & $urandom;
      end else if (roll < 9) begin
        bitmap = $urandom & $urandom;
      end else begin
        bitmap = $urandom | $urandom;
      end

      roll = $urandom_range(0, 9);
      if (roll == 0) asn = '0;
      else if (roll == 1) asn = '1;
      else asn = $urandom;

      pending_records.push_back('{ident, bitmap, asn});
    end
    records_planned = pending_records.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (records_taken < records_planned || expected_entries.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_entries.size() != 0) begin
      fault_count += expected_entries.size();
      $display("%0d predicted entries never arrived", expected_entries.size());
    end
    $display("Sent %0d records (%0d with zero identifier), checked %0d entries",
             records_taken, zero_idents, entries_checked);
    $display("Largest expansion %0d entries from one record, %0d faults",
             most_entries, fault_count);
    if (fault_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/psbd_pkg.sv
rtl/core/psbd_ctrl.sv
rtl/core/psbd_datapath.sv
rtl/core/prefix_subtree_bitmap_decoder_top.sv
rtl/core/psbd_checker.sv
sim/tb.sv
